// ===== sv/scsa_pkg.sv =====
// Shared constants, size table and status codes for the size class slot allocator.
package scsa_pkg;

    localparam int DEF_NUM_CLASSES     = 16;
    localparam int DEF_SLOTS_PER_CLASS = 14;

    localparam int SIZE_W   = 19;
    localparam int IDX_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd2;

    localparam logic [IDX_W-1:0] IDX_NONE = 5'h1F;

    localparam int SIZE_TABLE_LEN = 16;

    localparam logic [SIZE_W-1:0] SIZE_TABLE [SIZE_TABLE_LEN] = '{
        19'd12,    19'd24,    19'd40,    19'd72,
        19'd136,   19'd264,   19'd520,   19'd1032,
        19'd2056,  19'd4104,  19'd8200,  19'd16392,
        19'd32776, 19'd65544, 19'd131080, 19'd262152
    };

    function automatic logic [SIZE_W-1:0] class_size(input logic [IDX_W-1:0] idx);
        logic [SIZE_W-1:0] sz;
        if (idx[IDX_W-1]) begin
            sz = SIZE_TABLE[SIZE_TABLE_LEN-1];
        end else begin
            sz = SIZE_TABLE[idx[IDX_W-2:0]];
        end
        return sz;
    endfunction

endpackage

// ===== sv/size_class_slot_allocator.sv =====
// Size class slot allocator: class pick, used map memory read-modify-write, result register.
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+------------------
//  s_      | in        | mode, request_length, free_class, free_slot  | s_valid / s_ready
//  m_      | out       | status, class_index, slot_index, buffer_size | m_valid / m_ready
//
// Each word goes through ST_IDLE and ST_MOD: the used map row is read from the memory on
// accept and modified and written back in ST_MOD; a new word is taken only in ST_IDLE.
// After reset the used map reads as all free at once through per-row valid bits.
// The result waits in an output register; the next word is taken meanwhile.
// While the output register is full and not taken, the modify step holds.
module size_class_slot_allocator
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
    parameter int SLOTS_PER_CLASS = DEF_SLOTS_PER_CLASS
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_mode,
    input  logic [LEN_W-1:0]        s_request_length,
    input  logic signed [IDX_W-1:0] s_free_class,
    input  logic signed [IDX_W-1:0] s_free_slot,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic signed [IDX_W-1:0] m_class_index,
    output logic signed [IDX_W-1:0] m_slot_index,
    output logic [SIZE_W-1:0]       m_buffer_size
);

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam logic [5:0] NUM_CLASSES_V = 6'(NUM_CLASSES);
    localparam logic [6:0] NUM_SLOTS_V   = 7'(SLOTS_PER_CLASS);

    typedef enum logic {
        ST_IDLE,
        ST_MOD
    } state_t;

    state_t                     state_reg, state_next;
    logic [SLOTS_PER_CLASS-1:0] mem [NUM_CLASSES];
    logic [SLOTS_PER_CLASS-1:0] mem_q;
    logic [NUM_CLASSES-1:0]     row_valid_reg, row_valid_next;

    logic [CLS_W-1:0]           addr_reg, addr_next;
    logic [SLOT_W-1:0]          fs_reg, fs_next;
    logic                       op_free_reg, op_free_next;
    logic                       free_ok_reg, free_ok_next;
    logic                       cls_ok_reg, cls_ok_next;

    logic                       m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]        m_status_reg, m_status_next;
    logic [IDX_W-1:0]           m_class_reg, m_class_next;
    logic [IDX_W-1:0]           m_slot_reg, m_slot_next;
    logic [SIZE_W-1:0]          m_size_reg, m_size_next;

    logic                       accept;
    logic                       advance;
    logic                       mem_we;
    logic [SLOTS_PER_CLASS-1:0] mem_wdata;
    logic [SLOTS_PER_CLASS-1:0] row_cur;
    logic                       cls_found;
    logic [CLS_W-1:0]           cls_sel;
    logic                       slot_found;
    logic [SLOT_W-1:0]          slot_sel;
    logic                       free_ok;
    logic [6:0]                 fs_ext;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign advance       = (state_reg == ST_MOD) && (!m_valid_reg || m_ready);
    assign fs_ext        = {2'b00, s_free_slot};
    assign row_cur       = row_valid_reg[addr_reg] ? mem_q : '0;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_class_index = m_class_reg;
    assign m_slot_index  = m_slot_reg;
    assign m_buffer_size = m_size_reg;

    always_comb begin
        cls_found = 1'b0;
        cls_sel   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ({13'd0, class_size(IDX_W'(c))} > s_request_length) begin
                cls_found = 1'b1;
                cls_sel   = CLS_W'(c);
            end
        end
    end

    always_comb begin
        slot_found = 1'b0;
        slot_sel   = '0;
        for (int s = SLOTS_PER_CLASS - 1; s >= 0; s--) begin
            if (!row_cur[s]) begin
                slot_found = 1'b1;
                slot_sel   = SLOT_W'(s);
            end
        end
    end

    assign free_ok = !s_free_class[IDX_W-1] && !s_free_slot[IDX_W-1] &&
                     ({1'b0, s_free_class} < NUM_CLASSES_V) &&
                     (fs_ext < NUM_SLOTS_V);

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        fs_next        = fs_reg;
        op_free_next   = op_free_reg;
        free_ok_next   = free_ok_reg;
        cls_ok_next    = cls_ok_reg;
        row_valid_next = row_valid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_class_next   = m_class_reg;
        m_slot_next    = m_slot_reg;
        m_size_next    = m_size_reg;
        mem_we         = 1'b0;
        mem_wdata      = row_cur;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_free_next = s_mode;
                    free_ok_next = free_ok;
                    cls_ok_next  = cls_found;
                    fs_next      = fs_ext[SLOT_W-1:0];
                    addr_next    = s_mode ? s_free_class[CLS_W-1:0] : cls_sel;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD: begin
                if (advance) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_OK;
                    m_class_next  = IDX_NONE;
                    m_slot_next   = IDX_NONE;
                    m_size_next   = '0;
                    if (op_free_reg) begin
                        mem_we    = free_ok_reg;
                        mem_wdata = row_cur & ~(SLOTS_PER_CLASS'(1) << fs_reg);
                    end else if (!cls_ok_reg) begin
                        m_status_next = STATUS_TOO_LONG;
                    end else if (!slot_found) begin
                        m_status_next = STATUS_NO_SLOT;
                    end else begin
                        mem_we       = 1'b1;
                        mem_wdata    = row_cur | (SLOTS_PER_CLASS'(1) << slot_sel);
                        m_class_next = IDX_W'(addr_reg);
                        m_slot_next  = IDX_W'(slot_sel);
                        m_size_next  = class_size(IDX_W'(addr_reg));
                    end
                    if (mem_we) begin
                        row_valid_next[addr_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mem_q <= mem[addr_next];
        end
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        addr_reg     <= addr_next;
        fs_reg       <= fs_next;
        op_free_reg  <= op_free_next;
        free_ok_reg  <= free_ok_next;
        cls_ok_reg   <= cls_ok_next;
        m_status_reg <= m_status_next;
        m_class_reg  <= m_class_next;
        m_slot_reg   <= m_slot_next;
        m_size_reg   <= m_size_next;
    end

    a_accept_to_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_MOD)
        else $error("accepted word did not enter modify step");

    a_fail_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |->
            m_class_index == IDX_NONE && m_slot_index == IDX_NONE && m_buffer_size == '0)
        else $error("failure word carries class, slot or size");

    a_alloc_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_class_index != IDX_NONE |->
            m_status == STATUS_OK && m_buffer_size != '0)
        else $error("allocation word without size");

    a_write_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_MOD && advance)
        else $error("used map written outside modify step");

    a_row_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> row_valid_reg[$past(addr_reg)])
        else $error("written row not marked valid");

endmodule
